/* rtl/sbda_pkg.sv */
`default_nettype none

package sbda_pkg;

  localparam int DATA_W     = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int CHAR_W     = 7;
  // one shift-and-adjust cell per input bit
  localparam int N_CELLS    = DATA_W;
  localparam int CNT_W      = $clog2(NUM_DIGITS + 1);

  // character slot of the final digit (slot 0 is the sign)
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NUM_DIGITS);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;

  // word carried along the cell chain
  typedef struct packed {
    logic              neg;
    logic [BCD_W-1:0]  bcd;
    logic [DATA_W-1:0] bin;
  } cell_data_t;

endpackage

`default_nettype wire

/* rtl/sbda_if.sv */
`default_nettype none

interface sbda_in_if import sbda_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sbda_out_if import sbda_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ascii_char;
  logic              last_char;

  modport source (output valid, output ascii_char, output last_char, input ready);
  modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

`default_nettype wire

/* rtl/sbda_cell.sv */
`default_nettype none

// One double-dabble step: add 3 to every digit of 5 or more, then shift
// the next binary bit into the BCD word.
module sbda_cell import sbda_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  output logic       up_ready,
  input  cell_data_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output cell_data_t dn_data
);

  logic [BCD_W-1:0] adj;

  always_comb begin
    for (int j = 0; j < NUM_DIGITS; j++) begin
      if (up_data.bcd[4*j +: 4] >= 4'd5) begin
        adj[4*j +: 4] = up_data.bcd[4*j +: 4] + 4'd3;
      end else begin
        adj[4*j +: 4] = up_data.bcd[4*j +: 4];
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data.neg <= up_data.neg;
      dn_data.bcd <= {adj[BCD_W-2:0], up_data.bin[DATA_W-1]};
      dn_data.bin <= {up_data.bin[DATA_W-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

/* rtl/sbda_serial.sv */
`default_nettype none

// Holds one converted value and sends sign then ten digits, one a request.
module sbda_serial import sbda_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         up_valid,
  output logic         up_ready,
  input  cell_data_t   up_data,
  sbda_out_if.source   chr
);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic              neg;
  logic [BCD_W-1:0]  bcd;
  logic              take;
  logic              done;

  assign take     = chr.valid && chr.ready;
  assign done     = take && (cnt == LAST_IDX);
  assign up_ready = !busy || done;

  assign chr.valid     = busy;
  assign chr.last_char = (cnt == LAST_IDX);

  always_comb begin
    if (cnt == '0) begin
      chr.ascii_char = neg ? CHAR_MINUS : CHAR_PLUS;
    end else begin
      chr.ascii_char = CHAR_ZERO + CHAR_W'(bcd[BCD_W-1 -: 4]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (up_valid && up_ready) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (take) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  // top nibble is always the digit on show
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      neg <= up_data.neg;
      bcd <= up_data.bcd;
    end else if (take && (cnt != '0)) begin
      bcd <= {bcd[BCD_W-5:0], 4'b0000};
    end
  end

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    busy && (cnt != '0) |-> bcd[BCD_W-1 -: 4] <= 4'd9)
    else $error("digit out of decimal range");

  a_bin_drained: assert property (@(posedge clk) disable iff (rst)
    up_valid |-> up_data.bin == '0)
    else $error("binary bits left after last cell");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= LAST_IDX)
    else $error("character slot beyond last digit");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    busy && !chr.ready |=> busy && $stable(cnt))
    else $error("serialiser moved while stalled");

endmodule

`default_nettype wire

/* rtl/signed_binary_to_decimal_ascii_core.sv */
`default_nettype none

// Signed binary to decimal ASCII converter.
// num (sink): one signed 32-bit value per request.
// chr (source): eleven characters per value, the sign '-' or '+' first,
//   then ten decimal digits most significant first with leading zeros;
//   last_char marks the tenth digit. The most negative value converts to
//   "-2147483648".
// The magnitude enters a chain of 32 double-dabble cells, one input bit
// per cell, each cell a register stage with its own valid. Cells hand
// data on every cycle the next stage can take it and close up bubbles,
// so several values may be in flight at once.
// The sign appears once the value has passed all 32 cells into the
// serialiser. Throughput is bounded by the single character port; the
//   serialiser reloads in the cycle its last digit is taken.
// Stalls: when chr.ready is low the current character holds; the chain
//   keeps filling until all 32 cells are full, then num.ready drops.
// Reset clears all valid flags and the serialiser; nothing is emitted.
module signed_binary_to_decimal_ascii_core import sbda_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sbda_in_if.sink    num,
  sbda_out_if.source chr
);

  logic [DATA_W-1:0] mag;
  logic              valid [0:N_CELLS];
  logic              ready [0:N_CELLS];
  cell_data_t        data  [0:N_CELLS];

  // unsigned magnitude, so the most negative value needs no special case
  assign mag = num.value[DATA_W-1] ? (~num.value + DATA_W'(1)) : num.value;

  assign valid[0]    = num.valid;
  assign num.ready   = ready[0];
  assign data[0].neg = num.value[DATA_W-1];
  assign data[0].bcd = '0;
  assign data[0].bin = mag;

  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    sbda_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (valid[g]),
      .up_ready (ready[g]),
      .up_data  (data[g]),
      .dn_valid (valid[g+1]),
      .dn_ready (ready[g+1]),
      .dn_data  (data[g+1])
    );
  end

  sbda_serial u_serial (
    .clk      (clk),
    .rst      (rst),
    .up_valid (valid[N_CELLS]),
    .up_ready (ready[N_CELLS]),
    .up_data  (data[N_CELLS]),
    .chr      (chr)
  );

endmodule

`default_nettype wire

/* verif/tb_signed_binary_to_decimal_ascii_core.sv */
`default_nettype none

// Testbench for the signed binary to decimal ASCII converter.
// Each value request is predicted at acceptance as eleven characters (sign,
// then ten digits) and queued; the character monitor compares every accepted
// character and its last flag against the head of that queue.
module tb_signed_binary_to_decimal_ascii_core;
  import sbda_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // no acceptance on either channel for this many cycles means a hang
  localparam int HANG_LIMIT  = 2000;
  // drain allowance after the last expected character: chain depth plus margin
  localparam int DRAIN_WAIT  = 40;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } dec_char_t;

  logic clk = 1'b0;
  logic rst;

  sbda_in_if  num_if ();
  sbda_out_if chr_if ();

  signed_binary_to_decimal_ascii_core u_top (
    .clk (clk),
    .rst (rst),
    .num (num_if),
    .chr (chr_if)
  );

  always #2 clk = ~clk;

  // characters still owed by the block, oldest first
  dec_char_t chars_due[$];
  int        err_count = 0;
  int        hang_cycles = 0;

  // idling density in percent; zero turns idling off on that side
  int gap_pct   = 0;
  int stall_pct = 0;

  // powers of ten that sit on digit boundaries
  int unsigned pow10[10] = '{32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000,
                             32'd100000, 32'd1000000, 32'd10000000,
                             32'd100000000, 32'd1000000000};

  task automatic report_mismatch(input string what);
    $display("MISMATCH t=%0t %s", $realtime, what);
    err_count++;
  endtask

  // Sign first, then the unsigned magnitude split into ten decimal digits.
  // Negation is done on 32 unsigned bits so the most negative value is fine.
  function automatic void queue_decimal_chars(input logic [DATA_W-1:0] v);
    logic              is_neg;
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] weight;
    logic [DATA_W-1:0] digit;
    dec_char_t         c;
    is_neg = v[DATA_W-1];
    mag    = is_neg ? (DATA_W'(0) - v) : v;
    c.ch   = is_neg ? CHAR_MINUS : CHAR_PLUS;
    c.last = 1'b0;
    chars_due.push_back(c);
    weight = DATA_W'(pow10[NUM_DIGITS-1]);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      digit  = mag / weight;
      mag    = mag - digit * weight;
      weight = weight / 10;
      c.ch   = CHAR_ZERO + CHAR_W'(digit);
      c.last = (i == NUM_DIGITS - 1);
      chars_due.push_back(c);
    end
  endfunction

  // One value request. valid is left high after acceptance so that a
  // following request without a gap never sees valid drop and rise in
  // one step; a gap lowers it and puts junk on the bus.
  task automatic send_value(input logic [DATA_W-1:0] v);
    int gap;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 6);
      num_if.valid <= 1'b0;
      num_if.value <= $urandom;
      repeat (gap) @(posedge clk);
    end
    num_if.valid <= 1'b1;
    num_if.value <= v;
    do @(posedge clk); while (!num_if.ready);
    queue_decimal_chars(v);
  endtask

  // Random value with a bias towards digit boundaries and the extremes.
  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2:    v = DATA_W'($urandom_range(0, 20)) - DATA_W'(10);
      3: begin
        v = DATA_W'(pow10[$urandom_range(0, 9)]) + DATA_W'($urandom_range(0, 4))
            - DATA_W'(2);
        if ($urandom_range(0, 1)) v = DATA_W'(0) - v;
      end
      4: begin
        // around the most negative and most positive values
        v = {1'b1, {(DATA_W-1){1'b0}}} + DATA_W'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) v = v - DATA_W'(4);
      end
      default: begin
        v = $urandom >> $urandom_range(0, DATA_W - 1);
        if ($urandom_range(0, 1)) v = DATA_W'(0) - v;
      end
    endcase
    return v;
  endfunction

  // Zero, the extremes, digit boundaries and alternating bit patterns.
  task automatic test_directed_values();
    gap_pct   = 25;
    stall_pct = 25;
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hFFFF_FFFF);            // -1
    send_value(32'h7FFF_FFFF);            // most positive
    send_value(32'h8000_0000);            // most negative, unsigned magnitude
    send_value(32'h8000_0001);
    send_value(32'd9);
    send_value(32'd10);
    send_value(-32'sd10);
    send_value(32'd999999999);
    send_value(32'd1000000000);
    send_value(-32'sd1000000000);
    send_value(32'd1234567890);
    send_value(-32'sd1234567890);
    send_value(32'd2000000000);
    send_value(-32'sd2147483647);
    send_value(32'h5555_5555);
    send_value(32'hAAAA_AAAA);
    send_value(32'd1999999999);
    send_value(-32'sd99);
  endtask

  // Random values in phases of differing idling density, including
  // phases with none at all.
  task automatic test_random_values();
    int gap_opts[4]   = '{0, 10, 40, 70};
    int stall_opts[4] = '{0, 15, 45, 70};
    for (int i = 0; i < 180; i++) begin
      if (i % 25 == 0) begin
        gap_pct   = gap_opts[$urandom_range(0, 3)];
        stall_pct = stall_opts[$urandom_range(0, 3)];
      end
      send_value(pick_value());
    end
  endtask

  // Back-to-back requests with the character port always ready: the
  // chain fills up and the serialiser has to reload without a bubble.
  task automatic test_steady_stream();
    gap_pct   = 0;
    stall_pct = 0;
    for (int i = 0; i < 30; i++) send_value(pick_value());
  endtask

  // Character sink: stalls come in bursts.
  initial begin
    chr_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        chr_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        chr_if.ready <= 1'b1;
      end
    end
  end

  // Character monitor: one compare per field against the oldest expectation.
  always @(posedge clk) begin
    dec_char_t exp_c;
    if (!rst && chr_if.valid && chr_if.ready) begin
      if (chars_due.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                  chr_if.ascii_char, chr_if.last_char));
      end else begin
        exp_c = chars_due.pop_front();
        if (chr_if.ascii_char !== exp_c.ch)
          report_mismatch($sformatf("ascii_char 0x%02h, want 0x%02h",
                                    chr_if.ascii_char, exp_c.ch));
        if (chr_if.last_char !== exp_c.last)
          report_mismatch($sformatf("last_char %0b, want %0b",
                                    chr_if.last_char, exp_c.last));
      end
    end
  end

  // Watchdog: cycles with no request accepted on either side.
  always @(posedge clk) begin
    if (rst || (num_if.valid && num_if.ready) || (chr_if.valid && chr_if.ready)) begin
      hang_cycles <= 0;
    end else begin
      hang_cycles <= hang_cycles + 1;
      if (hang_cycles + 1 >= HANG_LIMIT) begin
        $display("tb_signed_binary_to_decimal_ascii_core NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst          <= 1'b1;
    num_if.valid <= 1'b0;
    num_if.value <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed_values();
    test_random_values();
    test_steady_stream();
    num_if.valid <= 1'b0;

    // let the chain drain, then give it time to show anything extra
    while (chars_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_count == 0) begin
      $display("tb_signed_binary_to_decimal_ascii_core OK");
    end else begin
      $display("tb_signed_binary_to_decimal_ascii_core NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
